// ===== rtl/core/wbau_pkg.sv =====
// Shared types, constants and the arctangent table of the waypoint bearing and arrival unit.
package wbau_pkg;

   localparam int CORDIC_STEPS_DEFAULT = 16;

   localparam logic [2:0] REG_TARGET_LATITUDE        = 3'd0;
   localparam logic [2:0] REG_TARGET_LONGITUDE       = 3'd1;
   localparam logic [2:0] REG_RELATIVE_ALTITUDE_MM   = 3'd2;
   localparam logic [2:0] REG_USE_REFERENCE_ALTITUDE = 3'd3;
   localparam logic [2:0] REG_REFERENCE_ALTITUDE_MM  = 3'd4;
   localparam logic [2:0] REG_FIXED_YAW              = 3'd5;
   localparam logic [2:0] REG_ACCEPTANCE_RADIUS_MM   = 3'd6;

   // Division by 10000 or 100000 drops four or five low bits, then divides by 625 or 3125
   // one 16-bit digit at a time with reciprocals that are exact for every partial dividend.
   localparam int DIV_WIDTH  = 52;
   localparam int DIV_DIGITS = 3;

   localparam logic [28:0] RECIP_MM         = 29'd109951163;
   localparam logic [28:0] RECIP_CDEG       = 29'd351843721;
   localparam logic [11:0] ODD_DIVISOR_MM   = 12'd625;
   localparam logic [11:0] ODD_DIVISOR_CDEG = 12'd3125;

   localparam logic [31:0] METERS_PER_DEG = 32'd111132;
   localparam logic [15:0] YAW_FULL       = 16'd36000;
   localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
   localparam logic signed [33:0] DEG180_Z    = 34'sd1800000000;
   localparam logic signed [33:0] DEG360_Z    = 34'sd3600000000;

   typedef struct packed {
      logic signed [30:0] target_latitude;
      logic signed [31:0] target_longitude;
      logic [16:0]        relative_altitude_mm;
      logic               use_reference_altitude;
      logic signed [24:0] reference_altitude_mm;
      logic [15:0]        fixed_yaw;
      logic [19:0]        acceptance_radius_mm;
   } cfg_type;

   typedef struct packed {
      logic               dlat_neg;
      logic [31:0]        dlat_mag;
      logic               dlon_neg;
      logic [31:0]        dlon_mag;
      logic [30:0]        zcos;
      logic               cos_neg;
      logic signed [24:0] alt;
      logic [25:0]        dalt_mag;
      logic [15:0]        cyaw_mod;
   } work_type;

   function automatic logic [28:0] atan_lookup(input logic [4:0] k);
      logic [28:0] a;
      case (k)
         5'd0:  a = 29'd450000000;
         5'd1:  a = 29'd265650512;
         5'd2:  a = 29'd140362435;
         5'd3:  a = 29'd71250163;
         5'd4:  a = 29'd35763344;
         5'd5:  a = 29'd17899106;
         5'd6:  a = 29'd8951737;
         5'd7:  a = 29'd4476142;
         5'd8:  a = 29'd2238105;
         5'd9:  a = 29'd1119057;
         5'd10: a = 29'd559529;
         5'd11: a = 29'd279765;
         5'd12: a = 29'd139882;
         5'd13: a = 29'd69941;
         5'd14: a = 29'd34971;
         5'd15: a = 29'd17485;
         5'd16: a = 29'd8743;
         5'd17: a = 29'd4371;
         5'd18: a = 29'd2186;
         5'd19: a = 29'd1093;
         5'd20: a = 29'd546;
         5'd21: a = 29'd273;
         5'd22: a = 29'd137;
         5'd23: a = 29'd68;
         5'd24: a = 29'd34;
         5'd25: a = 29'd17;
         5'd26: a = 29'd9;
         5'd27: a = 29'd4;
         5'd28: a = 29'd2;
         5'd29: a = 29'd1;
         5'd30: a = 29'd1;
         default: a = 29'd0;
      endcase
      return a;
   endfunction

endpackage

// ===== rtl/core/wbau_chan_if.sv =====
// Valid/ready channel interfaces for telemetry items and result items.
interface wbau_req_if;
   logic               valid;
   logic               ready;
   logic signed [30:0] current_latitude;
   logic signed [31:0] current_longitude;
   logic [15:0]        current_yaw;
   logic signed [24:0] current_altitude_mm;
   logic signed [24:0] home_altitude_mm;

   modport source (output valid, current_latitude, current_longitude, current_yaw,
                   current_altitude_mm, home_altitude_mm, input ready);
   modport sink (input valid, current_latitude, current_longitude, current_yaw,
                 current_altitude_mm, home_altitude_mm, output ready);
endinterface

interface wbau_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        command_yaw;
   logic signed [24:0] command_altitude_mm;
   logic               arrival_status;

   modport source (output valid, command_yaw, command_altitude_mm, arrival_status,
                   input ready);
   modport sink (input valid, command_yaw, command_altitude_mm, arrival_status,
                 output ready);
endinterface

// ===== rtl/core/wbau_front.sv =====
// Front end: accepts telemetry items and reduces them to offsets, angles and altitudes.
module wbau_front import wbau_pkg::*; (
   wbau_req_if.sink   req,
   input  cfg_type    cfg,
   input  logic       full,
   output logic       push,
   output work_type   work
);

   logic signed [31:0] dlat;
   logic signed [32:0] dlon;
   logic signed [32:0] dlon_w;
   logic signed [31:0] mlat;
   logic [31:0]        mlat_abs;
   logic [30:0]        half;
   logic signed [25:0] base;
   logic signed [25:0] alt_sum;
   logic signed [24:0] alt;
   logic signed [25:0] dalt;

   assign req.ready = !full;
   assign push = req.valid && !full;

   always_comb begin
      dlat = $signed({cfg.target_latitude[30], cfg.target_latitude})
           - $signed({req.current_latitude[30], req.current_latitude});
      dlon = $signed({cfg.target_longitude[31], cfg.target_longitude})
           - $signed({req.current_longitude[31], req.current_longitude});
      if (dlon > 33'sd1800000000) begin
         dlon_w = dlon - 33'sd3600000000;
      end else if (dlon < -33'sd1800000000) begin
         dlon_w = dlon + 33'sd3600000000;
      end else begin
         dlon_w = dlon;
      end
      mlat = $signed({cfg.target_latitude[30], cfg.target_latitude})
           + $signed({req.current_latitude[30], req.current_latitude});
      mlat_abs = mlat[31] ? 32'(-mlat) : mlat;
      half = mlat_abs[31:1];

      base = cfg.use_reference_altitude
           ? $signed({cfg.reference_altitude_mm[24], cfg.reference_altitude_mm})
           : $signed({req.home_altitude_mm[24], req.home_altitude_mm});
      alt_sum = base + $signed({9'b0, cfg.relative_altitude_mm});
      if (alt_sum > 26'sd16777215) begin
         alt = 25'sh0FFFFFF;
      end else if (alt_sum < -26'sd16777216) begin
         alt = 25'sh1000000;
      end else begin
         alt = alt_sum[24:0];
      end
      dalt = $signed({alt[24], alt})
           - $signed({req.current_altitude_mm[24], req.current_altitude_mm});

      work.dlat_neg = dlat[31];
      work.dlat_mag = dlat[31] ? 32'(-dlat) : dlat;
      work.dlon_neg = dlon_w[32];
      work.dlon_mag = dlon_w[32] ? 32'(-dlon_w) : dlon_w[31:0];
      if (half > 31'd900000000) begin
         work.zcos    = 31'd1800000000 - half;
         work.cos_neg = 1'b1;
      end else begin
         work.zcos    = half;
         work.cos_neg = 1'b0;
      end
      work.alt      = alt;
      work.dalt_mag = dalt[25] ? 26'(-dalt) : dalt;
      work.cyaw_mod = (req.current_yaw >= YAW_FULL) ? req.current_yaw - YAW_FULL
                                                    : req.current_yaw;
   end

endmodule

// ===== rtl/core/wbau_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
module wbau_queue import wbau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output work_type pop_data,
   output logic     empty
);

   work_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/wbau_cdiv.sv =====
// Shared divider by 10000 or 100000: reciprocal multiplication over 16-bit digits.
module wbau_cdiv import wbau_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_WIDTH-1:0] dividend,
   input  logic                 sel_cdeg,
   output logic                 done,
   output logic [DIV_WIDTH-1:0] quotient
);

   localparam logic [1:0] LastDigit = 2'(DIV_DIGITS - 1);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        phase_ff, phase_in;
   logic        sel_ff, sel_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [47:0] num_ff, num_in;
   logic [47:0] quo_ff, quo_in;
   logic [11:0] rem_ff, rem_in;
   logic [27:0] x_ff, x_in;
   logic [56:0] prod_ff, prod_in;
   logic [28:0] recip;
   logic [11:0] dvs;
   logic [15:0] qd;
   logic [27:0] qd_dvs;
   logic [27:0] rem_full;

   assign done     = done_ff;
   assign quotient = DIV_WIDTH'(quo_ff);

   always_comb begin
      recip    = sel_ff ? RECIP_CDEG : RECIP_MM;
      dvs      = sel_ff ? ODD_DIVISOR_CDEG : ODD_DIVISOR_MM;
      qd       = sel_ff ? prod_ff[55:40] : prod_ff[51:36];
      qd_dvs   = {12'b0, qd} * {16'b0, dvs};
      rem_full = x_ff - qd_dvs;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      x_in     = x_ff;
      prod_in  = prod_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         sel_in   = sel_cdeg;
         cnt_in   = 2'd0;
         num_in   = sel_cdeg ? {1'b0, dividend[51:5]} : dividend[51:4];
         quo_in   = 48'd0;
         rem_in   = 12'd0;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            x_in     = {rem_ff, num_ff[47:32]};
            prod_in  = {29'b0, x_in} * {28'b0, recip};
            num_in   = {num_ff[31:0], 16'd0};
            phase_in = 1'b1;
         end else begin
            quo_in   = {quo_ff[31:0], qd};
            rem_in   = rem_full[11:0];
            phase_in = 1'b0;
            cnt_in   = cnt_ff + 2'd1;
            if (cnt_ff == LastDigit) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      sel_ff   <= sel_in;
      cnt_ff   <= cnt_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      x_ff     <= x_in;
      prod_ff  <= prod_in;
   end

endmodule

// ===== rtl/core/wbau_back.sv =====
// Back end: sequences the shared CORDIC, multiplier and divider and drives the result item.
module wbau_back import wbau_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       empty,
   input  work_type   head,
   output logic       pop,
   wbau_rsp_if.source rsp
);

   localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_COS  = 5'd1;
   localparam logic [4:0] ST_MN   = 5'd2;
   localparam logic [4:0] ST_DN0  = 5'd3;
   localparam logic [4:0] ST_DN   = 5'd4;
   localparam logic [4:0] ST_ME   = 5'd5;
   localparam logic [4:0] ST_ML   = 5'd6;
   localparam logic [4:0] ST_MH   = 5'd7;
   localparam logic [4:0] ST_SUM  = 5'd8;
   localparam logic [4:0] ST_DE0  = 5'd9;
   localparam logic [4:0] ST_DE   = 5'd10;
   localparam logic [4:0] ST_SQN  = 5'd11;
   localparam logic [4:0] ST_SQE  = 5'd12;
   localparam logic [4:0] ST_SQA  = 5'd13;
   localparam logic [4:0] ST_SQR  = 5'd14;
   localparam logic [4:0] ST_CMP  = 5'd15;
   localparam logic [4:0] ST_VEC  = 5'd16;
   localparam logic [4:0] ST_DB0  = 5'd17;
   localparam logic [4:0] ST_DB   = 5'd18;
   localparam logic [4:0] ST_OUT  = 5'd19;

   logic [4:0]         state_ff, state_in;
   work_type           w_ff, w_in;
   logic [4:0]         i_ff, i_in;
   logic signed [35:0] x_ff, x_in;
   logic signed [35:0] y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [63:0]        prod_ff, prod_in;
   logic [31:0]        c_mag_ff, c_mag_in;
   logic               c_neg_ff, c_neg_in;
   logic [16:0]        ua_hi_ff, ua_hi_in;
   logic [63:0]        lo_prod_ff, lo_prod_in;
   logic [51:0]        eres_ff, eres_in;
   logic signed [31:0] north_ff, north_in;
   logic [31:0]        north_mag_ff, north_mag_in;
   logic signed [31:0] east_ff, east_in;
   logic [31:0]        east_mag_ff, east_mag_in;
   logic [63:0]        h2_ff, h2_in;
   logic [63:0]        d2_ff, d2_in;
   logic               arrived_ff, arrived_in;
   logic [15:0]        yaw_ff, yaw_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_yaw_ff, rsp_yaw_in;
   logic signed [24:0] rsp_alt_ff, rsp_alt_in;
   logic               rsp_arr_ff, rsp_arr_in;

   logic [31:0]        mul_a, mul_b;
   logic               ccw;
   logic signed [35:0] xs, ys, cx, cy;
   logic signed [33:0] at, cz, zw;
   logic [95:0]        esum;
   logic               div_start, div_done;
   logic [51:0]        div_dvd, div_q;
   logic               div_sel;
   logic signed [31:0] sat_val;
   logic [51:0]        cd;

   function automatic logic signed [31:0] sat_mm(input logic [51:0] q, input logic neg);
      logic signed [31:0] s;
      if (neg) begin
         s = (q > 52'h80000000) ? 32'sh80000000 : $signed(32'(-q[31:0]));
      end else begin
         s = (q > 52'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(q[31:0]);
      end
      return s;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] s);
      return s[31] ? 32'(-s) : s;
   endfunction

   wbau_cdiv u_cdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .sel_cdeg (div_sel),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.command_yaw         = rsp_yaw_ff;
   assign rsp.command_altitude_mm = rsp_alt_ff;
   assign rsp.arrival_status      = rsp_arr_ff;

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      ccw = (state_ff == ST_COS) ? !z_ff[33] : y_ff[35];
      xs  = x_ff >>> i_ff;
      ys  = y_ff >>> i_ff;
      at  = $signed({5'b0, atan_lookup(i_ff)});
      cx  = ccw ? x_ff - ys : x_ff + ys;
      cy  = ccw ? y_ff + xs : y_ff - xs;
      cz  = ccw ? z_ff - at : z_ff + at;
      esum = {prod_ff, 32'b0} + {32'b0, lo_prod_ff};
      if (z_ff < 34'sd0) begin
         zw = z_ff + DEG360_Z;
      end else if (z_ff >= DEG360_Z) begin
         zw = z_ff - DEG360_Z;
      end else begin
         zw = z_ff;
      end
      cd = (div_q >= 52'd36000) ? div_q - 52'd36000 : div_q;
      sat_val = sat_mm(div_q, (state_ff == ST_DN) ? w_ff.dlat_neg
                                                  : (w_ff.dlon_neg ^ c_neg_ff));
   end

   always_comb begin
      state_in     = state_ff;
      w_in         = w_ff;
      i_in         = i_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      c_mag_in     = c_mag_ff;
      c_neg_in     = c_neg_ff;
      ua_hi_in     = ua_hi_ff;
      lo_prod_in   = lo_prod_ff;
      eres_in      = eres_ff;
      north_in     = north_ff;
      north_mag_in = north_mag_ff;
      east_in      = east_ff;
      east_mag_in  = east_mag_ff;
      h2_in        = h2_ff;
      d2_in        = d2_ff;
      arrived_in   = arrived_ff;
      yaw_in       = yaw_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_yaw_in   = rsp_yaw_ff;
      rsp_alt_in   = rsp_alt_ff;
      rsp_arr_in   = rsp_arr_ff;
      mul_a        = 32'd0;
      mul_b        = 32'd0;
      pop          = 1'b0;
      div_start    = 1'b0;
      div_dvd      = 52'd0;
      div_sel      = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               w_in     = head;
               x_in     = CORDIC_GAIN;
               y_in     = 36'sd0;
               z_in     = $signed({3'b0, head.zcos});
               i_in     = 5'd0;
               state_in = ST_COS;
            end
         end
         ST_COS, ST_VEC: begin
            x_in = cx;
            y_in = cy;
            z_in = cz;
            i_in = i_ff + 5'd1;
            if (i_ff == LastStep) begin
               state_in = (state_ff == ST_COS) ? ST_MN : ST_DB0;
            end
         end
         ST_MN: begin
            c_mag_in = x_ff[35] ? 32'(-x_ff) : x_ff[31:0];
            c_neg_in = w_ff.cos_neg ^ x_ff[35];
            mul_a    = w_ff.dlat_mag;
            mul_b    = METERS_PER_DEG;
            state_in = ST_DN0;
         end
         ST_DN0: begin
            div_start = 1'b1;
            div_dvd   = prod_ff[51:0] + 52'd5000;
            state_in  = ST_DN;
         end
         ST_DN: begin
            if (div_done) begin
               north_in     = sat_val;
               north_mag_in = mag32(sat_val);
               state_in     = ST_ME;
            end
         end
         ST_ME: begin
            mul_a    = w_ff.dlon_mag;
            mul_b    = METERS_PER_DEG;
            state_in = ST_ML;
         end
         ST_ML: begin
            ua_hi_in = prod_ff[48:32];
            mul_a    = prod_ff[31:0];
            mul_b    = c_mag_ff;
            state_in = ST_MH;
         end
         ST_MH: begin
            lo_prod_in = prod_ff;
            mul_a      = {15'b0, ua_hi_ff};
            mul_b      = c_mag_ff;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            eres_in  = esum[81:30];
            state_in = ST_DE0;
         end
         ST_DE0: begin
            div_start = 1'b1;
            div_dvd   = eres_ff + 52'd5000;
            state_in  = ST_DE;
         end
         ST_DE: begin
            if (div_done) begin
               east_in     = sat_val;
               east_mag_in = mag32(sat_val);
               state_in    = ST_SQN;
            end
         end
         ST_SQN: begin
            mul_a    = north_mag_ff;
            mul_b    = north_mag_ff;
            state_in = ST_SQE;
         end
         ST_SQE: begin
            h2_in    = prod_ff;
            mul_a    = east_mag_ff;
            mul_b    = east_mag_ff;
            state_in = ST_SQA;
         end
         ST_SQA: begin
            h2_in    = h2_ff + prod_ff;
            mul_a    = {6'b0, w_ff.dalt_mag};
            mul_b    = {6'b0, w_ff.dalt_mag};
            state_in = ST_SQR;
         end
         ST_SQR: begin
            d2_in    = h2_ff + prod_ff;
            mul_a    = {12'b0, cfg.acceptance_radius_mm};
            mul_b    = {12'b0, cfg.acceptance_radius_mm};
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (d2_ff <= prod_ff) begin
               arrived_in = 1'b1;
            end
            if (cfg.fixed_yaw <= YAW_FULL) begin
               yaw_in   = cfg.fixed_yaw;
               state_in = ST_OUT;
            end else if (h2_ff <= 64'd1) begin
               yaw_in   = w_ff.cyaw_mod;
               state_in = ST_OUT;
            end else begin
               if (north_ff[31]) begin
                  x_in = -36'(north_ff);
                  y_in = -36'(east_ff);
                  z_in = DEG180_Z;
               end else begin
                  x_in = 36'(north_ff);
                  y_in = 36'(east_ff);
                  z_in = 34'sd0;
               end
               i_in     = 5'd0;
               state_in = ST_VEC;
            end
         end
         ST_DB0: begin
            div_start = 1'b1;
            div_dvd   = {20'b0, zw[31:0]} + 52'd50000;
            div_sel   = 1'b1;
            state_in  = ST_DB;
         end
         ST_DB: begin
            if (div_done) begin
               yaw_in   = cd[15:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_yaw_in   = yaw_ff;
               rsp_alt_in   = w_ff.alt;
               rsp_arr_in   = arrived_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         arrived_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         arrived_ff   <= arrived_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff         <= w_in;
      i_ff         <= i_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      prod_ff      <= prod_in;
      c_mag_ff     <= c_mag_in;
      c_neg_ff     <= c_neg_in;
      ua_hi_ff     <= ua_hi_in;
      lo_prod_ff   <= lo_prod_in;
      eres_ff      <= eres_in;
      north_ff     <= north_in;
      north_mag_ff <= north_mag_in;
      east_ff      <= east_in;
      east_mag_ff  <= east_mag_in;
      h2_ff        <= h2_in;
      d2_ff        <= d2_in;
      yaw_ff       <= yaw_in;
      rsp_yaw_ff   <= rsp_yaw_in;
      rsp_alt_ff   <= rsp_alt_in;
      rsp_arr_ff   <= rsp_arr_in;
   end

endmodule

// ===== rtl/core/waypoint_bearing_arrival_unit.sv =====
// Top level of the waypoint bearing and arrival unit: configuration registers and assembly.
// The back end works through one item at a time and takes the next one only once it has offered
// the result of the last; the shared CORDIC unit, multiplier and divider in the back end set the
// rate, and a two-entry queue lets the front end take up to two more items.
// Reset is synchronous and active high; it restores all register defaults and clears arrival.
module waypoint_bearing_arrival_unit import wbau_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   wbau_req_if.sink    req_chan,
   wbau_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   work_type push_data, pop_data;
   logic     push, pop, full, empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_TARGET_LATITUDE:        cfg_in.target_latitude = csr_wdata[30:0];
            REG_TARGET_LONGITUDE:       cfg_in.target_longitude = csr_wdata;
            REG_RELATIVE_ALTITUDE_MM:   cfg_in.relative_altitude_mm = csr_wdata[16:0];
            REG_USE_REFERENCE_ALTITUDE: cfg_in.use_reference_altitude = csr_wdata[0];
            REG_REFERENCE_ALTITUDE_MM:  cfg_in.reference_altitude_mm = csr_wdata[24:0];
            REG_FIXED_YAW:              cfg_in.fixed_yaw = csr_wdata[15:0];
            REG_ACCEPTANCE_RADIUS_MM:   cfg_in.acceptance_radius_mm = csr_wdata[19:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_latitude        <= 31'sd0;
         cfg_ff.target_longitude       <= 32'sd0;
         cfg_ff.relative_altitude_mm   <= 17'd10000;
         cfg_ff.use_reference_altitude <= 1'b0;
         cfg_ff.reference_altitude_mm  <= 25'sd0;
         cfg_ff.fixed_yaw              <= 16'd36001;
         cfg_ff.acceptance_radius_mm   <= 20'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   wbau_front u_front (
      .req  (req_chan),
      .cfg  (cfg_ff),
      .full (full),
      .push (push),
      .work (push_data)
   );

   wbau_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   wbau_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .empty (empty),
      .head  (pop_data),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

`ifndef SYNTHESIS
   // Once arrival is reported, every later result item reports it too.
   a_arrival_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.arrival_status) |=>
      (!rsp_chan.valid || rsp_chan.arrival_status))
      else $error("arrival status dropped after being set");

   // No result item is offered in the cycle after reset.
   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result item valid right after reset");

   // The queue is never popped while empty nor pushed while full.
   a_queue_safe: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty) && !(push && full))
      else $error("queue overflow or underflow");
`endif

endmodule
